FILE: rtl/delayed_pulse_energy_gate_core_macros.svh
// Assertion macros for the delayed pulse energy gate core.
// Depends on nothing; clk and rst_n must exist where the macros are used.
`ifndef DELAYED_PULSE_ENERGY_GATE_CORE_MACROS_SVH
`define DELAYED_PULSE_ENERGY_GATE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only out of reset.
`define DPEG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define DPEG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPEG_ASSERT(lbl, prop, msg)
`define DPEG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/dpeg_pkg.sv
// Shared types and constants for the delayed pulse energy gate.
// No dependencies.
`default_nettype none

package dpeg_pkg;

  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int WIDTH_W    = 16;
  localparam int SLOT_W     = 32;
  localparam int SUM_SHIFT  = 8;
  localparam int PROD_SHIFT = 10;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WIDTH_W-1:0]         width_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [RING_AW-1:0]         pos_t;

  localparam pos_t   RING_LAST = pos_t'(RING_DEPTH - 1);
  localparam width_t MPW_RESET = width_t'(1000);

endpackage

`default_nettype wire

FILE: rtl/delayed_pulse_energy_gate_core.sv
// Delayed pulse energy gate: items pass stage 2 registers, then the result registers.
// One item per cycle unless out_stall stalls; stage 1 does at most one ring write and
// one ring read, stage 2 scales the slot value with one 24x16 multiply and runs the
// width counter. Reset is synchronous, active low; max_pulse_width resets to 1000.
// The ring is not swept: a first-lap flag makes unvisited slots read as zero, so
// items are taken from the first cycle after reset.
// Depends on dpeg_pkg and delayed_pulse_energy_gate_core_macros.svh.
`default_nettype none
`include "delayed_pulse_energy_gate_core_macros.svh"

module delayed_pulse_energy_gate_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire dpeg_pkg::sample_t in_sample,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_gate_on,
  input  wire logic             cfg_wr_en,
  input  wire dpeg_pkg::width_t cfg_wr_data
);
  import dpeg_pkg::*;

  localparam int PROD_W = SLOT_W - SUM_SHIFT + WIDTH_W;
  localparam int W_W    = PROD_W - PROD_SHIFT;

  // Configuration
  width_t mpw_r;

  // Stage 1 state
  pos_t   pos_r, start_r;
  logic   integ_r, prev_pos_r, lap_r;
  slot_t  acc_r;

  // Stage 2 registers
  logic   s2_valid_r, s2_ovr_r;
  slot_t  s2_ovr_data_r, rd_data_r;

  // Result side
  width_t rw_r;
  logic   out_valid_r, out_gate_r;

  slot_t  ring_mem [RING_DEPTH];

  logic   adv, in_xfer;
  logic   samp_pos, start_pulse, integ_mid, integ_nxt;
  pos_t   start_mid, pos_nxt;
  slot_t  acc_nxt;
  logic [SLOT_W:0] acc_sum;
  logic   wr_en;
  pos_t   wr_addr;
  slot_t  wr_data;
  logic   ovr_nxt;
  slot_t  ovr_data_nxt;

  slot_t             value;
  logic [PROD_W-1:0] prod;
  logic [W_W-1:0]    w_full;
  width_t            w_clamp, rw_mid, rw_nxt;
  logic              gate_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign in_xfer  = in_valid && adv;

  // ---------------- Stage 1: ring update and prefetch ----------------
  always_comb begin
    samp_pos    = !in_sample[SAMPLE_W-1] && (in_sample != '0);
    start_pulse = samp_pos && !prev_pos_r;
    integ_mid   = start_pulse || integ_r;
    start_mid   = start_pulse ? pos_r : start_r;

    // At a fresh start the sum starts at zero instead of from acc_r.
    acc_sum = {1'b0, (start_pulse ? '0 : acc_r)} +
              (SLOT_W+1)'($unsigned(in_sample));
    if (samp_pos && integ_mid) begin
      acc_nxt = acc_sum[SLOT_W] ? '1 : acc_sum[SLOT_W-1:0];
    end else begin
      acc_nxt = acc_r;
    end

    pos_nxt   = (pos_r == RING_LAST) ? '0 : pos_r + 1'b1;
    integ_nxt = integ_mid && (start_mid != pos_nxt);

    // At most one write per item: park an abandoned sum, else settle the current slot
    // (mark with 1 or clear). A new start slot lives in acc_r until it ends.
    if (start_pulse) begin
      wr_en   = integ_r;
      wr_addr = start_r;
      wr_data = acc_r;
    end else begin
      wr_en   = 1'b1;
      wr_addr = pos_r;
      wr_data = samp_pos ? slot_t'(1) : '0;
    end

    // Bypass the ring where its registered read would be stale or the slot unvisited.
    if (integ_mid && (start_mid == pos_nxt)) begin
      ovr_nxt      = 1'b1;
      ovr_data_nxt = acc_nxt;
    end else if (wr_en && (wr_addr == pos_nxt)) begin
      ovr_nxt      = 1'b1;
      ovr_data_nxt = wr_data;
    end else if (!lap_r && (pos_nxt != '0)) begin
      ovr_nxt      = 1'b1;
      ovr_data_nxt = '0;
    end else begin
      ovr_nxt      = 1'b0;
      ovr_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data_r     <= ring_mem[pos_nxt];
      s2_ovr_r      <= ovr_nxt;
      s2_ovr_data_r <= ovr_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      start_r    <= '0;
      integ_r    <= 1'b0;
      prev_pos_r <= 1'b0;
      lap_r      <= 1'b0;
      acc_r      <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s2_valid_r <= in_valid;
      end
      if (in_xfer) begin
        pos_r      <= pos_nxt;
        start_r    <= start_mid;
        integ_r    <= integ_nxt;
        prev_pos_r <= samp_pos;
        acc_r      <= acc_nxt;
        if (pos_r == RING_LAST) begin
          lap_r <= 1'b1;
        end
      end
    end
  end

  // ---------------- Stage 2: width scaling and gate counter ----------------
  always_comb begin
    value   = s2_ovr_r ? s2_ovr_data_r : rd_data_r;
    prod    = PROD_W'(value[SLOT_W-1:SUM_SHIFT]) * PROD_W'(mpw_r);
    w_full  = prod[PROD_W-1:PROD_SHIFT];
    w_clamp = (w_full > W_W'(mpw_r)) ? mpw_r : w_full[WIDTH_W-1:0];

    if (value > slot_t'(1)) begin
      rw_mid = w_clamp;
    end else if (value == '0) begin
      rw_mid = '0;
    end else begin
      rw_mid = rw_r;
    end

    gate_nxt = (rw_mid != '0);
    rw_nxt   = gate_nxt ? rw_mid - 1'b1 : rw_mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpw_r       <= MPW_RESET;
      rw_r        <= '0;
      out_valid_r <= 1'b0;
      out_gate_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mpw_r <= cfg_wr_data;
      end
      if (adv) begin
        out_valid_r <= s2_valid_r;
        if (s2_valid_r) begin
          rw_r       <= rw_nxt;
          out_gate_r <= gate_nxt;
        end
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_gate_on = out_gate_r;

  // ---------------- Checks ----------------
  `DPEG_ASSERT(a_integ_not_on_start, integ_r |-> (start_r != pos_r), "integrating on start slot")
  `DPEG_ASSERT(a_xfer_reaches_s2, (in_valid && !in_stall) |=> s2_valid_r, "transfer lost in stage 1")
  `DPEG_ASSERT(a_s2_reaches_out, (s2_valid_r && !in_stall) |=> out_valid, "stage 2 item lost")
  `DPEG_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid && !s2_valid_r && !lap_r), "reset did not clear")

endmodule

`default_nettype wire
